// ===== rtl/gpm_pkg.sv =====
// shared types and constants of the glob pattern matcher
// used by gpm_cell and glob_pattern_matcher; no dependencies
package gpm_pkg;

    localparam int unsigned PATTERN_MAX_DEF = 32;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_NAME   = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        EK_LIT  = 2'd0,
        EK_ANY  = 2'd1,
        EK_STAR = 2'd2,
        EK_SET  = 2'd3
    } t_ek;

    // broadcast to every cell
    typedef struct packed {
        logic       take;
        t_op        op;
        logic [7:0] char_byte;
        logic       put;
        t_ek        put_kind;
        logic       put_flag;
        logic       close_flag;
    } t_cell_ctl;

    // where a cell sits relative to the stored pattern
    typedef struct packed {
        logic first;
        logic valid;
        logic at_len;
        logic at_last;
    } t_cell_pos;

    // handed from one cell to the next
    typedef struct packed {
        logic star_pass;
        logic set_arm;
        logic set_hit;
        logic adv;
    } t_link;

endpackage

// ===== rtl/gpm_cell.sv =====
// one pattern position: stored element plus its live flag
// depends on gpm_pkg
module gpm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gpm_pkg::t_cell_ctl i_ctl,
    input  gpm_pkg::t_cell_pos i_pos,
    input  gpm_pkg::t_link     i_link,
    output gpm_pkg::t_link     o_link,
    output logic              o_live
);
    import gpm_pkg::*;

    t_ek        r_kind;
    logic       r_flag;
    logic [7:0] r_char;
    logic       r_act;
    logic       n_act;

    logic is_lit, is_any, is_star, is_set;
    logic live, char_eq, armed, hit, fire;

    always_ff @(posedge i_clk) begin
        if (i_ctl.put && i_pos.at_len) begin
            r_kind <= i_ctl.put_kind;
            r_flag <= i_ctl.put_flag;
            r_char <= i_ctl.char_byte;
        end else if (i_ctl.close_flag && i_pos.at_last) begin
            r_flag <= 1'b1;
        end
    end

    always_comb begin
        is_lit  = i_pos.valid && (r_kind == EK_LIT);
        is_any  = i_pos.valid && (r_kind == EK_ANY);
        is_star = i_pos.valid && (r_kind == EK_STAR);
        is_set  = i_pos.valid && (r_kind == EK_SET);
        live    = r_act | i_link.star_pass;
        char_eq = (r_char == i_ctl.char_byte);
        armed   = i_link.set_arm | live;
        hit     = i_link.set_hit | char_eq;
        fire    = is_set && r_flag && armed && hit;

        o_live           = live;
        o_link.star_pass = is_star && live;
        o_link.set_arm   = is_set && !r_flag && armed;
        o_link.set_hit   = is_set && !r_flag && hit;
        o_link.adv       = (is_lit && live && char_eq) || (is_any && !r_flag && live) || fire;
    end

    always_comb begin
        n_act = r_act;
        unique case (i_ctl.op)
            OP_CLEAR, OP_END: n_act = i_pos.first;
            OP_NAME:          n_act = i_link.adv | (is_star && live);
            OP_APPEND:        n_act = r_act;
            default:          n_act = r_act;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= i_pos.first;
        end else if (i_ctl.take) begin
            r_act <= n_act;
        end
    end

endmodule

// ===== rtl/glob_pattern_matcher.sv =====
// Glob matcher: one beat per clock of any kind (clear, pattern byte, name byte, end of
// name), with no reset sweep. An end-of-name beat gives its result in the output
// register on the next cycle; while a result waits, a new beat is taken only in a cycle
// in which that result is taken too. The
// clock period is set by the ripple through the row of PATTERN_MAX cells: live flags
// carried across runs of stars and match state carried across the members of a set,
// both of which run like an adder carry chain.
// depends on gpm_pkg and gpm_cell
module glob_pattern_matcher #(
    parameter int unsigned PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_char_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_matched,
    output logic       o_overflow
);
    import gpm_pkg::*;

    localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_set_start, n_set_start;
    logic             r_inside, n_inside;
    logic             r_ovf, n_ovf;
    logic             r_act_end, n_act_end;
    logic             r_out_valid, r_matched, r_out_ovf;

    t_op       op;
    logic      accept;
    logic      want_put, room, close_set;
    t_ek       put_kind;
    logic      put_flag;
    t_cell_ctl ctl;

    t_link              link [0:PATTERN_MAX];
    logic [PATTERN_MAX:0] live;
    logic [LEN_W-1:0]   fin_idx;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign op          = t_op'(i_kind);
    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;
    assign o_overflow  = r_out_ovf;

    // pattern byte decode
    always_comb begin
        want_put    = 1'b0;
        put_kind    = EK_LIT;
        put_flag    = 1'b0;
        close_set   = 1'b0;
        n_inside    = r_inside;
        n_set_start = r_set_start;
        if (r_inside) begin
            if (i_char_byte == CH_RBRACK) begin
                n_inside = 1'b0;
                if (r_len > r_set_start) begin
                    close_set = 1'b1;
                end else begin
                    want_put = 1'b1;
                    put_kind = EK_ANY;
                    put_flag = 1'b1;
                end
            end else begin
                want_put = 1'b1;
                put_kind = EK_SET;
            end
        end else begin
            case (i_char_byte)
                CH_LBRACK: begin
                    n_inside    = 1'b1;
                    n_set_start = r_len;
                end
                CH_STAR: begin
                    want_put = 1'b1;
                    put_kind = EK_STAR;
                end
                CH_QUEST: begin
                    want_put = 1'b1;
                    put_kind = EK_ANY;
                end
                default: begin
                    want_put = 1'b1;
                    put_kind = EK_LIT;
                end
            endcase
        end
    end

    assign room = (r_len < LEN_W'(PATTERN_MAX));

    always_comb begin
        ctl.take       = accept;
        ctl.op         = op;
        ctl.char_byte  = i_char_byte;
        ctl.put        = accept && (op == OP_APPEND) && want_put && room;
        ctl.put_kind   = put_kind;
        ctl.put_flag   = put_flag;
        ctl.close_flag = accept && (op == OP_APPEND) && close_set;
    end

    always_comb begin
        n_len     = r_len;
        n_ovf     = r_ovf;
        n_act_end = r_act_end;
        unique case (op)
            OP_CLEAR: begin
                n_len     = '0;
                n_ovf     = 1'b0;
                n_act_end = 1'b0;
            end
            OP_APPEND: begin
                n_len = r_len + LEN_W'(ctl.put);
                n_ovf = r_ovf | (want_put && !room);
            end
            OP_NAME: n_act_end = link[PATTERN_MAX].adv;
            OP_END:  n_act_end = 1'b0;
            default: n_act_end = r_act_end;
        endcase
    end

    assign link[0] = '0;

    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        t_cell_pos pos;
        always_comb begin
            pos.first   = (g == 0);
            pos.valid   = (r_len > LEN_W'(g));
            pos.at_len  = (r_len == LEN_W'(g));
            pos.at_last = (r_len == LEN_W'(g + 1));
        end

        gpm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_pos   (pos),
            .i_link  (link[g]),
            .o_link  (link[g+1]),
            .o_live  (live[g])
        );
    end

    assign live[PATTERN_MAX] = r_act_end | link[PATTERN_MAX].star_pass;

    // an open set does not take part; the name must reach the position of its bracket
    assign fin_idx = r_inside ? r_set_start : r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_set_start <= '0;
            r_inside    <= 1'b0;
            r_ovf       <= 1'b0;
            r_act_end   <= 1'b0;
        end else if (accept) begin
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_act_end <= n_act_end;
            if (op == OP_CLEAR) begin
                r_inside <= 1'b0;
            end else if (op == OP_APPEND) begin
                r_inside    <= n_inside;
                r_set_start <= n_set_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && (op == OP_END)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (op == OP_END)) begin
            r_matched <= live[fin_idx];
            r_out_ovf <= r_ovf;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(PATTERN_MAX))
        else $error("pattern length past store depth");

    a_set_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside |-> (r_set_start <= r_len))
        else $error("open set starts beyond pattern end");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (op == OP_CLEAR)) |=> (r_len == '0 && !r_inside && !r_ovf && !r_act_end))
        else $error("clear did not empty the pattern");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (op == OP_END)) |=> (o_out_valid && !r_act_end))
        else $error("end of name gave no result");

endmodule
